// ----- rtl/core/mrsd_pkg.sv -----
// ----------------------------------------------------------------------------
// mrsd_pkg - move record stream decoder shared definitions
// Record form codes, queue entry type, direction table and length decode.
// ----------------------------------------------------------------------------
package mrsd_pkg;

  // form selected by the low two bits of a record's first byte
  localparam logic [1:0] FormPack  = 2'd0;
  localparam logic [1:0] FormShort = 2'd1;
  localparam logic [1:0] FormTwo   = 2'd2;
  localparam logic [1:0] FormLong  = 2'd3;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // one queue entry: a single move, a packed triple or a truncation
  typedef struct packed {
    logic        trunc;
    logic        is_pack;
    logic [5:0]  pack_dirs;
    logic [8:0]  dir;
    logic [31:0] tstamp;
  } mrsd_entry_t;

  function automatic logic [8:0] dir_of_index(input logic [2:0] idx);
    logic [8:0] d;
    case (idx)
      3'd0: d = 9'd1;
      3'd1: d = 9'd2;
      3'd2: d = 9'd4;
      3'd3: d = 9'd8;
      3'd4: d = 9'd3;
      3'd5: d = 9'd6;
      3'd6: d = 9'd9;
      3'd7: d = 9'd12;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] length_of(input logic [7:0] b);
    logic [2:0] len;
    case (b[1:0])
      FormPack:  len = 3'd1;
      FormShort: len = 3'd1;
      FormTwo:   len = 3'd2;
      default: begin
        if (b[4]) begin
          len = 3'd2 + {1'b0, b[3:2]};
        end else begin
          len = 3'd4;
        end
      end
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/core/mrsd_front.sv -----
// ----------------------------------------------------------------------------
// mrsd_front - record gatherer
// Collects record bytes, decodes the form and advances the running time.
// ----------------------------------------------------------------------------
module mrsd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_first_byte,
  input  logic                 in_last_byte,
  output logic                 push,
  output mrsd_pkg::mrsd_entry_t push_entry
);

  logic [2:0]  held_r, held_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [31:0] time_r, time_nxt;
  logic [7:0]  rb_r [4];

  logic        acc;
  logic [2:0]  held_e, len_e, len_c;
  logic [31:0] time_e, delay, time_new;
  logic        incomplete;
  logic [7:0]  b, b0, b1, v2, v3;
  logic [1:0]  n;
  logic [8:0]  dir;

  assign acc = in_valid && !in_stall;
  assign b   = in_data_byte;

  always_comb begin
    held_e = in_first_byte ? 3'd0 : held_r;
    len_e  = in_first_byte ? 3'd0 : len_r;
    time_e = in_first_byte ? 32'hFFFF_FFFF : time_r;
    len_c  = (held_e == 3'd0) ? mrsd_pkg::length_of(b) : len_e;
    incomplete = ({1'b0, held_e} + 4'd1) < {1'b0, len_c};
    b0 = (held_e == 3'd0) ? b : rb_r[0];
    b1 = (held_e >= 3'd2) ? rb_r[1] : b;
    v2 = (len_c == 3'd3) ? b : rb_r[2];
    v3 = (len_c == 3'd4) ? b : rb_r[3];
    n  = b0[3:2];
    delay = 32'd0;
    dir   = 9'd0;
    case (b0[1:0])
      mrsd_pkg::FormPack: begin
        delay = 32'd11;
      end
      mrsd_pkg::FormShort: begin
        dir   = mrsd_pkg::dir_of_index(b0[4:2]);
        delay = {29'd0, b0[7:5]};
      end
      mrsd_pkg::FormTwo: begin
        dir   = mrsd_pkg::dir_of_index(b0[4:2]);
        delay = {21'd0, b1, b0[7:5]};
      end
      default: begin
        if (b0[4]) begin
          dir   = {b1[5:0], b0[7:5]};
          delay = {30'd0, b1[7:6]};
          if (n >= 2'd1) delay = delay | {22'd0, v2, 2'd0};
          if (n >= 2'd2) delay = delay | {14'd0, v3, 10'd0};
          if (n == 2'd3) delay = delay | {6'd0, b, 18'd0};
        end else begin
          dir   = mrsd_pkg::dir_of_index({1'b0, b0[3:2]});
          delay = {5'd0, b, rb_r[2], b1, b0[7:5]};
        end
      end
    endcase
    time_new = time_e + delay + 32'd1;
  end

  always_comb begin
    held_nxt = held_r;
    len_nxt  = len_r;
    time_nxt = time_r;
    push     = 1'b0;
    push_entry = '0;
    if (acc) begin
      if (incomplete) begin
        held_nxt = held_e + 3'd1;
        len_nxt  = len_c;
        time_nxt = time_e;
        if (in_last_byte) begin
          held_nxt = 3'd0;
          len_nxt  = 3'd0;
          push     = 1'b1;
          push_entry.trunc = 1'b1;
        end
      end else begin
        held_nxt = 3'd0;
        len_nxt  = 3'd0;
        time_nxt = time_new;
        push     = 1'b1;
        push_entry.is_pack   = (b0[1:0] == mrsd_pkg::FormPack);
        push_entry.pack_dirs = b0[7:2];
        push_entry.dir       = dir;
        push_entry.tstamp    = (b0[1:0] == mrsd_pkg::FormPack) ? time_e : time_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 3'd0;
      len_r  <= 3'd0;
      time_r <= 32'hFFFF_FFFF;
    end else begin
      held_r <= held_nxt;
      len_r  <= len_nxt;
      time_r <= time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && incomplete) begin
      rb_r[held_e[1:0]] <= b;
    end
  end

endmodule

// ----- rtl/core/mrsd_queue.sv -----
// ----------------------------------------------------------------------------
// mrsd_queue - decoded entry queue
// Small FIFO between the record gatherer and the move expander.
// ----------------------------------------------------------------------------
module mrsd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mrsd_pkg::mrsd_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output mrsd_pkg::mrsd_entry_t head
);

  mrsd_pkg::mrsd_entry_t mem_r [mrsd_pkg::QDepth];
  logic [mrsd_pkg::QPtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [mrsd_pkg::QCntW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == mrsd_pkg::QCntW'(mrsd_pkg::QDepth));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + mrsd_pkg::QCntW'(push) - mrsd_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> !pop) else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((wr_r - rd_r) == cnt_r[mrsd_pkg::QPtrW-1:0]))
    else $error("queue pointers and count disagree");
`endif

endmodule

// ----- rtl/core/mrsd_back.sv -----
// ----------------------------------------------------------------------------
// mrsd_back - move expander
// Turns queue entries into registered moves, one per cycle when not stalled.
// ----------------------------------------------------------------------------
module mrsd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  mrsd_pkg::mrsd_entry_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [8:0]            out_move_dir,
  output logic [31:0]           out_move_time,
  output logic                  out_truncated,
  output logic                  out_last_of_run
);

  logic [1:0]  phase_r, phase_nxt;
  logic        valid_r, valid_nxt;
  logic [8:0]  dir_r, dir_nxt;
  logic [31:0] time_r, time_nxt;
  logic        trunc_r, trunc_nxt;
  logic        last_r, last_nxt;
  logic        load;
  logic [1:0]  pidx;
  logic [1:0]  step;

  assign load = head_valid && (!valid_r || !out_stall);
  assign step = phase_r + 2'd1;

  always_comb begin
    pidx = 2'd0;
    case (phase_r)
      2'd0: pidx = head.pack_dirs[1:0];
      2'd1: pidx = head.pack_dirs[3:2];
      2'd2: pidx = head.pack_dirs[5:4];
      default: pidx = 2'd0;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r && out_stall;
    dir_nxt   = dir_r;
    time_nxt  = time_r;
    trunc_nxt = trunc_r;
    last_nxt  = last_r;
    phase_nxt = phase_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      trunc_nxt = head.trunc;
      if (head.is_pack) begin
        dir_nxt   = mrsd_pkg::dir_of_index({1'b0, pidx});
        time_nxt  = head.tstamp + {28'd0, step, 2'd0};
        last_nxt  = (phase_r == 2'd2);
        pop       = (phase_r == 2'd2);
        phase_nxt = (phase_r == 2'd2) ? 2'd0 : step;
      end else begin
        dir_nxt   = head.dir;
        time_nxt  = head.tstamp;
        last_nxt  = 1'b1;
        pop       = 1'b1;
        phase_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
    dir_r   <= dir_nxt;
    time_r  <= time_nxt;
    trunc_r <= trunc_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_move_dir    = dir_r;
  assign out_move_time   = time_r;
  assign out_truncated   = trunc_r;
  assign out_last_of_run = last_r;

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3) else $error("expander phase out of range");
  a_phase_pack: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != 2'd0) |-> (head_valid && head.is_pack))
    else $error("mid-triple without packed head");
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && trunc_r) |-> (last_r && dir_r == 9'd0))
    else $error("truncation transfer malformed");
`endif

endmodule

// ----- rtl/core/move_record_stream_decoder_core.sv -----
// ----------------------------------------------------------------------------
// move_record_stream_decoder_core - move record stream decoder
// Decodes variable-length move records into timed moves.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_stall, in_data_byte, in_first_byte,
//           |           | in_last_byte
//   out     | output    | out_valid, out_stall, out_move_dir, out_move_time,
//           |           | out_truncated, out_last_of_run
//
// The gatherer takes one byte per cycle while in_stall is low and decodes
// a finished record in the cycle of its final byte; the expander sends one
// move per cycle while out_stall is low, so a packed byte yields three
// moves at the output. A four-entry queue sits between them; in_stall
// rises only when it is full. Entries pass the queue, then the output register.
// Synchronous active-low reset: time to all ones, queue and output empty.
// ----------------------------------------------------------------------------
module move_record_stream_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_move_dir,
  output logic [31:0] out_move_time,
  output logic        out_truncated,
  output logic        out_last_of_run
);

  logic                  push, full, pop, head_valid;
  mrsd_pkg::mrsd_entry_t push_entry, head;

  assign in_stall = full;

  mrsd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .push          (push),
    .push_entry    (push_entry)
  );

  mrsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mrsd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_move_dir    (out_move_dir),
    .out_move_time   (out_move_time),
    .out_truncated   (out_truncated),
    .out_last_of_run (out_last_of_run)
  );

endmodule
